// File: hw/rtl/spq_pkg.sv
// spq_pkg: shared constants, codes and types of the stable priority queue
// used by spq_cell and stable_priority_queue; no dependencies

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FILL_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    // broadcast to every cell in the cycle an item is accepted
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry entry;
    } t_cell_ctl;

endpackage

// File: hw/rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds one entry
// depends on spq_pkg

module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_left_keep,
    input  spq_pkg::t_entry    i_left,
    input  spq_pkg::t_entry    i_right,
    output logic               o_keep,
    output spq_pkg::t_entry    o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // entry stays put when it sorts ahead of or ties with the new one
    assign o_keep  = i_occupied && (r_entry.prio <= i_ctl.entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_keep) begin
            if (i_left_keep) begin
                n_entry = i_ctl.entry;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: hw/rtl/stable_priority_queue.sv
// stable_priority_queue: sorted queue built as a chain of entry cells
// depends on spq_pkg and spq_cell
//
// channel   direction  handshake                 payload
// in        in         i_in_valid / o_in_stall   i_mode, i_item_value, i_item_priority
// out       out        o_out_valid / i_out_stall o_status, o_head_value,
//                                                o_head_priority, o_fill_level
//
// all cells compare and shift in parallel in the cycle an item is accepted, and
// its result sits in the output register the next cycle; one item per cycle is
// sustained while i_out_stall is low; the single output register is the only
// buffer, so o_in_stall is high only while a result waits and i_out_stall is high
// reset (i_rst_n low, synchronous) empties the queue and drops any waiting result
// cell contents are not reset; slots past the fill count are never read

module stable_priority_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_mode,
    input  logic signed [spq_pkg::DATA_W-1:0]  i_item_value,
    input  logic signed [spq_pkg::DATA_W-1:0]  i_item_priority,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic        [1:0]                  o_status,
    output logic signed [spq_pkg::DATA_W-1:0]  o_head_value,
    output logic signed [spq_pkg::DATA_W-1:0]  o_head_priority,
    output logic        [spq_pkg::FILL_W-1:0]  o_fill_level
);

    // entry count and output register
    logic [spq_pkg::CNT_W-1:0]          r_count;
    logic [spq_pkg::CNT_W-1:0]          n_count;
    logic                               r_out_valid;
    logic [1:0]                         r_status;
    logic [1:0]                         n_status;
    logic signed [spq_pkg::DATA_W-1:0]  r_head_value;
    logic signed [spq_pkg::DATA_W-1:0]  r_head_priority;
    logic [spq_pkg::FILL_W-1:0]         r_fill_level;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    spq_pkg::t_cell_ctl  ctl;

    // chain wiring, one element per cell
    spq_pkg::t_entry cell_entry [spq_pkg::CAPACITY];
    logic            cell_keep  [spq_pkg::CAPACITY];

    // a new item enters whenever the output register is free or drains now
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_full  = (r_count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign is_empty = (r_count == '0);

    assign ctl.ins        = accept && (i_mode == spq_pkg::MODE_INSERT) && !is_full;
    assign ctl.rem        = accept && (i_mode == spq_pkg::MODE_REMOVE) && !is_empty;
    assign ctl.entry.val  = i_item_value;
    assign ctl.entry.prio = i_item_priority;

    // slot 0 is the head; the new entry lands in the first cell that does not keep
    for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
        logic            left_keep;
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;

        if (g == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = ctl.entry;
        end else begin : g_body
            assign left_keep  = cell_keep[g-1];
            assign left_entry = cell_entry[g-1];
        end

        if (g == spq_pkg::CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_mid
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (spq_pkg::CNT_W'(g) < r_count),
            .i_left_keep (left_keep),
            .i_left      (left_entry),
            .i_right     (right_entry),
            .o_keep      (cell_keep[g]),
            .o_entry     (cell_entry[g])
        );
    end

    // result status and next count
    always_comb begin
        n_count = r_count;
        if (i_mode == spq_pkg::MODE_INSERT) begin
            if (is_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_status = spq_pkg::ST_INSERTED;
                n_count  = r_count + spq_pkg::CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = spq_pkg::ST_UNDERFLOW;
            end else begin
                n_status = spq_pkg::ST_REMOVED;
                n_count  = r_count - spq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_fill_level <= spq_pkg::FILL_W'(n_count);
            if (ctl.rem) begin
                r_head_value    <= cell_entry[0].val;
                r_head_priority <= cell_entry[0].prio;
            end else begin
                r_head_value    <= '0;
                r_head_priority <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_head_value    = r_head_value;
    assign o_head_priority = r_head_priority;
    assign o_fill_level    = r_fill_level;

`ifndef ASSERT_OFF
    // count never passes the number of cells
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // head and second slot stay in priority order
    a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= spq_pkg::CNT_W'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
        else $error("head slot out of order");

    // a remove on an empty queue reports underflow
    a_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == spq_pkg::MODE_REMOVE) && is_empty)
        |=> (o_out_valid && (o_status == spq_pkg::ST_UNDERFLOW)))
        else $error("underflow not reported");

    // an insert into a full queue leaves the count alone
    a_full_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == spq_pkg::MODE_INSERT) && is_full) |=> $stable(r_count))
        else $error("full insert changed count");
`endif

endmodule

// File: sim/stable_priority_queue_tb.sv
`timescale 1ns / 1ps
// stable_priority_queue_tb: self-checking bench for the stable priority queue
// drives directed and random insert/remove items; depends on spq_pkg and the rtl

module stable_priority_queue_tb;

    // one result of the queue, as seen on the output channel
    typedef struct packed {
        logic        [1:0]                 status;
        logic signed [spq_pkg::DATA_W-1:0] head_val;
        logic signed [spq_pkg::DATA_W-1:0] head_prio;
        logic        [spq_pkg::FILL_W-1:0] fill;
    } t_queue_result;

    // one row of the directed table; is_typed marks a result written in by hand
    typedef struct packed {
        logic                              mode;
        logic signed [spq_pkg::DATA_W-1:0] val;
        logic signed [spq_pkg::DATA_W-1:0] prio;
        logic                              is_typed;
        t_queue_result                     res;
    } t_directed_row;

    localparam int NUM_DIRECTED = 23;
    localparam int NUM_RANDOM   = 650;
    localparam int NUM_QUIET    = 100;   // last random items run with no idling

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic                              i_mode;
    logic signed [spq_pkg::DATA_W-1:0] i_item_value;
    logic signed [spq_pkg::DATA_W-1:0] i_item_priority;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic        [1:0]                 o_status;
    logic signed [spq_pkg::DATA_W-1:0] o_head_value;
    logic signed [spq_pkg::DATA_W-1:0] o_head_priority;
    logic        [spq_pkg::FILL_W-1:0] o_fill_level;

    // mirror of the queue contents, head at index 0
    spq_pkg::t_entry held_entries[$];
    // results owed by the queue, oldest first
    t_queue_result   awaited_results[$];

    int unsigned fail_count = 0;
    int unsigned idle_chance = 0;   // percent chance of an idle or stall burst
    bit          quiet = 1'b0;

    // directed table: extremes, ties, underflow and overflow
    t_directed_row directed_rows [NUM_DIRECTED] = '{
        // remove on an empty queue right after reset
        '{spq_pkg::MODE_REMOVE, 32'sh0, 32'sh0, 1'b1,
          '{spq_pkg::ST_UNDERFLOW, 32'sh0, 32'sh0, 5'd0}},
        // extreme values and priorities
        '{spq_pkg::MODE_INSERT, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd1}},
        '{spq_pkg::MODE_INSERT, 32'sh80000000, 32'sh80000000, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd2}},
        '{spq_pkg::MODE_INSERT, 32'sh0, 32'sh0, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd3}},
        '{spq_pkg::MODE_INSERT, 32'shFFFFFFFF, 32'shFFFFFFFF, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd4}},
        // equal priorities must leave in arrival order
        '{spq_pkg::MODE_INSERT, 32'sh1, 32'sh0, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd5}},
        '{spq_pkg::MODE_INSERT, 32'sh2, 32'sh0, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd6}},
        '{spq_pkg::MODE_INSERT, 32'sh55555555, 32'sh7FFFFFFF, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd7}},
        '{spq_pkg::MODE_INSERT, 32'shAAAAAAAA, 32'sh80000000, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd8}},
        '{spq_pkg::MODE_INSERT, 32'sh10, 32'sh5, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd9}},
        '{spq_pkg::MODE_INSERT, 32'sh11, 32'sh3, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd10}},
        '{spq_pkg::MODE_INSERT, 32'sh12, 32'sh5, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd11}},
        '{spq_pkg::MODE_INSERT, 32'sh13, -32'sh7, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd12}},
        '{spq_pkg::MODE_INSERT, 32'sh14, 32'sh64, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd13}},
        '{spq_pkg::MODE_INSERT, 32'sh15, 32'sh3, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd14}},
        '{spq_pkg::MODE_INSERT, 32'sh16, 32'sh12345678, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd15}},
        '{spq_pkg::MODE_INSERT, 32'sh17, 32'sh1, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd16}},
        // insert on a full queue is dropped
        '{spq_pkg::MODE_INSERT, 32'sh18, 32'sh0, 1'b1,
          '{spq_pkg::ST_FULL, 32'sh0, 32'sh0, 5'd16}},
        // heads come out in sorted order, checked against the mirror
        '{spq_pkg::MODE_REMOVE, 32'sh0, 32'sh0, 1'b0,
          '{spq_pkg::ST_REMOVED, 32'sh0, 32'sh0, 5'd0}},
        '{spq_pkg::MODE_REMOVE, 32'shFFFFFFFF, 32'shFFFFFFFF, 1'b0,
          '{spq_pkg::ST_REMOVED, 32'sh0, 32'sh0, 5'd0}},
        '{spq_pkg::MODE_REMOVE, 32'sh0, 32'sh0, 1'b0,
          '{spq_pkg::ST_REMOVED, 32'sh0, 32'sh0, 5'd0}},
        '{spq_pkg::MODE_INSERT, 32'sh19, 32'sh0, 1'b1,
          '{spq_pkg::ST_INSERTED, 32'sh0, 32'sh0, 5'd14}},
        '{spq_pkg::MODE_REMOVE, 32'sh0, 32'sh0, 1'b0,
          '{spq_pkg::ST_REMOVED, 32'sh0, 32'sh0, 5'd0}}
    };

    stable_priority_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority),
        .o_fill_level    (o_fill_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog, far beyond the slowest legal run (about 0.5 ms)
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 100) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // applies one accepted item to the mirror and returns the result it owes
    function automatic t_queue_result sorted_queue_step(input logic mode,
            input logic signed [spq_pkg::DATA_W-1:0] val,
            input logic signed [spq_pkg::DATA_W-1:0] prio);
        t_queue_result   res;
        spq_pkg::t_entry e;
        int              pos;
        res = '0;
        if (mode == spq_pkg::MODE_INSERT) begin
            if (held_entries.size() >= spq_pkg::CAPACITY) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                // go behind every entry of lower or equal priority
                pos = 0;
                while (pos < held_entries.size()
                       && $signed(held_entries[pos].prio) <= $signed(prio)) begin
                    pos++;
                end
                e.val  = val;
                e.prio = prio;
                held_entries.insert(pos, e);
                res.status = spq_pkg::ST_INSERTED;
            end
        end else begin
            if (held_entries.size() == 0) begin
                res.status = spq_pkg::ST_UNDERFLOW;
            end else begin
                e = held_entries.pop_front();
                res.status    = spq_pkg::ST_REMOVED;
                res.head_val  = e.val;
                res.head_prio = e.prio;
            end
        end
        res.fill = spq_pkg::FILL_W'(held_entries.size());
        return res;
    endfunction

    // presents one item, waits for it to be taken, then records what it owes
    task automatic drive_item(input logic mode,
            input logic signed [spq_pkg::DATA_W-1:0] val,
            input logic signed [spq_pkg::DATA_W-1:0] prio, input logic is_typed,
            input t_queue_result typed_res);
        t_queue_result predicted;
        int unsigned   gap;
        if (!quiet && $urandom_range(0, 99) < idle_chance) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_item_value    <= val;
        i_item_priority <= prio;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = sorted_queue_step(mode, val, prio);
        awaited_results.push_back(is_typed ? typed_res : predicted);
    endtask

    // output side: checks each taken result and stalls in random bursts
    initial begin
        t_queue_result got;
        t_queue_result want;
        int unsigned   stall_left;
        stall_left  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = '{o_status, o_head_value, o_head_priority, o_fill_level};
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result st=%0d val=%h pri=%h fill=%0d",
                        got.status, got.head_val, got.head_prio, got.fill));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.head_val !== want.head_val
                        || got.head_prio !== want.head_prio || got.fill !== want.fill) begin
                        report_mismatch($sformatf(
                            "got st=%0d val=%h pri=%h fill=%0d, want st=%0d val=%h pri=%h fill=%0d",
                            got.status, got.head_val, got.head_prio, got.fill,
                            want.status, want.head_val, want.head_prio, want.fill));
                    end
                end
            end
            if (quiet) begin
                stall_left = 0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < idle_chance) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // input side: reset, directed table, random items, drain
    initial begin
        logic                              mode;
        logic signed [spq_pkg::DATA_W-1:0] val;
        logic signed [spq_pkg::DATA_W-1:0] prio;
        bit                                filling;
        int unsigned                       pick;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_mode          <= spq_pkg::MODE_INSERT;
        i_item_value    <= '0;
        i_item_priority <= '0;
        filling = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_chance = 30;
        foreach (directed_rows[k]) begin
            drive_item(directed_rows[k].mode, directed_rows[k].val, directed_rows[k].prio,
                       directed_rows[k].is_typed, directed_rows[k].res);
        end

        // random part: sweep the fill level up and down so both full and
        // empty are reached often, with many priority ties on the way
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 40 == 0) begin
                // alternate busy, calm and idle-free stretches
                case ($urandom_range(0, 2))
                    0: idle_chance = 0;
                    1: idle_chance = 15;
                    default: idle_chance = 40;
                endcase
            end
            if (n >= NUM_RANDOM - NUM_QUIET) begin
                quiet = 1'b1;
            end
            if (held_entries.size() >= spq_pkg::CAPACITY) begin
                filling = 1'b0;
            end else if (held_entries.size() == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
                filling = ~filling;
            end
            mode = ($urandom_range(0, 99) < (filling ? 80 : 25)) ?
                   spq_pkg::MODE_INSERT : spq_pkg::MODE_REMOVE;
            val  = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                prio = $signed($urandom_range(0, 6)) - 3;
            end else if (pick < 70) begin
                prio = $urandom;
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0: prio = 32'sh80000000;
                    1: prio = 32'sh7FFFFFFF;
                    2: prio = -32'sh1;
                    default: prio = 32'sh0;
                endcase
            end else if (held_entries.size() > 0) begin
                // tie with an entry already held
                prio = held_entries[$urandom_range(0, held_entries.size() - 1)].prio;
            end else begin
                prio = $urandom;
            end
            drive_item(mode, val, prio, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        // results are registered, so a short tail catches any stray result
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
sim/stable_priority_queue_tb.sv
